FILE: rtl/core/alc_pkg.sv
// ============================================================================
// alc_pkg: shared types for the array list engine
// Operation and status codes, cell command and controller state.
// ============================================================================
package alc_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned IN_W    = 40;
    localparam int unsigned OUT_W   = 16;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_SEARCH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADIDX = 2'd2,
        ST_NOKEY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        C_HOLD,
        C_APPEND,
        C_INSERT,
        C_DELETE,
        C_MATCH,
        C_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op             op;
        logic [POS_W-1:0]     position;
        logic [COUNT_W-1:0]   fill;
        logic [VALUE_W-1:0]   value;
    } t_cell_cmd;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

endpackage

FILE: rtl/core/array_list_engine_core.sv
// ============================================================================
// array_list_engine_core: ordered list with append, insert, delete, search
// A row of entry cells under a small controller, with a registered result.
// ============================================================================
// Append, insert and delete update the row at once: every cell shifts or
// loads in parallel with its neighbor. A search first compares the key in
// all cells at once, then scans the entries in order as the hit bits move
// down the row toward cell 0, pausing while the result register is busy;
// no new item is taken until the search ends, and a search on an empty
// list answers without a scan.
// The result waits in an output register, so a new item is taken as soon as
// that register is free or being read. The capacity register may be written
// at any time the block is idle; values above DEPTH limit the list to DEPTH.
module array_list_engine_core #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration: capacity
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [alc_pkg::COUNT_W-1:0]   i_cfg_data,
    // Input items
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [alc_pkg::IN_W-1:0]      i_s_tdata,  // position[5:0], value[37:6]
    input  logic [1:0]                    i_s_tuser,  // op[1:0]
    // Result items
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [alc_pkg::OUT_W-1:0]     o_m_tdata   // status[1:0], found[7:2], count[14:8]
);
    import alc_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [COUNT_W-1:0]  r_fill;
    logic [COUNT_W-1:0]  n_fill;
    logic [COUNT_W-1:0]  r_cap;
    logic [COUNT_W-1:0]  r_scan;
    logic [COUNT_W-1:0]  n_scan;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [POS_W-1:0]    r_out_found;
    logic [COUNT_W-1:0]  r_out_count;

    t_cell_cmd           w_cmd;
    logic                w_load;
    t_status             w_status;
    logic [POS_W-1:0]    w_found;

    logic [VALUE_W-1:0]  w_entry [DEPTH];
    logic                w_hit   [DEPTH];

    t_op                 w_op;
    logic [POS_W-1:0]    w_pos;
    logic [VALUE_W-1:0]  w_value;
    logic                w_fire;
    logic                w_out_free;
    logic                w_full;
    logic                w_bad_ins;
    logic                w_bad_del;
    logic                w_scan_last;
    logic [COUNT_W:0]    w_scan_inc;

    assign w_op    = t_op'(i_s_tuser);
    assign w_pos   = i_s_tdata[POS_W-1:0];
    assign w_value = i_s_tdata[POS_W +: VALUE_W];

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_fire     = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign w_full    = (r_fill >= r_cap) || (32'(r_fill) >= 32'(DEPTH));
    assign w_bad_ins = {1'b0, w_pos} > r_fill;
    assign w_bad_del = {1'b0, w_pos} >= r_fill;

    assign w_scan_inc  = {1'b0, r_scan} + {{COUNT_W{1'b0}}, 1'b1};
    assign w_scan_last = w_scan_inc >= {1'b0, r_fill};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_fire && (w_op == OP_SEARCH) && (r_fill != '0)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_out_free && (w_hit[0] || w_scan_last)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Cell commands, fill update and result
    always_comb begin
        w_cmd.op       = C_HOLD;
        w_cmd.position = w_pos;
        w_cmd.fill     = r_fill;
        w_cmd.value    = w_value;
        n_fill         = r_fill;
        n_scan         = r_scan;
        w_load         = 1'b0;
        w_status       = ST_OK;
        w_found        = '0;
        case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    case (w_op)
                        OP_APPEND: begin
                            w_load = 1'b1;
                            if (w_full) begin
                                w_status = ST_FULL;
                            end else begin
                                w_cmd.op = C_APPEND;
                                n_fill   = r_fill + 1'b1;
                            end
                        end
                        OP_INSERT: begin
                            w_load = 1'b1;
                            if (w_full) begin
                                w_status = ST_FULL;
                            end else if (w_bad_ins) begin
                                w_status = ST_BADIDX;
                            end else begin
                                w_cmd.op = C_INSERT;
                                n_fill   = r_fill + 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            w_load = 1'b1;
                            if (w_bad_del) begin
                                w_status = ST_BADIDX;
                            end else begin
                                w_cmd.op = C_DELETE;
                                n_fill   = r_fill - 1'b1;
                            end
                        end
                        default: begin
                            if (r_fill == '0) begin
                                w_load   = 1'b1;
                                w_status = ST_NOKEY;
                            end else begin
                                w_cmd.op = C_MATCH;
                                n_scan   = '0;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Cell 0 always holds the hit bit of the entry at r_scan.
                if (w_out_free) begin
                    if (w_hit[0]) begin
                        w_load   = 1'b1;
                        w_found  = r_scan[POS_W-1:0];
                    end else if (w_scan_last) begin
                        w_load   = 1'b1;
                        w_status = ST_NOKEY;
                    end else begin
                        w_cmd.op = C_SHIFT;
                        n_scan   = w_scan_inc[COUNT_W-1:0];
                    end
                end
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_cap       <= COUNT_W'(64);
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_scan  <= n_scan;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= w_status;
            r_out_found  <= w_found;
            r_out_count  <= n_fill;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [VALUE_W-1:0] w_prev;
            logic [VALUE_W-1:0] w_next;
            logic               w_next_hit;
            if (gi == 0) begin : g_first
                assign w_prev = '0;
            end else begin : g_mid_prev
                assign w_prev = w_entry[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_next     = '0;
                assign w_next_hit = 1'b0;
            end else begin : g_mid_next
                assign w_next     = w_entry[gi+1];
                assign w_next_hit = w_hit[gi+1];
            end
            alc_cell #(
                .IDX (gi)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (w_cmd),
                .i_prev_entry (w_prev),
                .i_next_entry (w_next),
                .i_next_hit   (w_next_hit),
                .o_entry      (w_entry[gi]),
                .o_hit        (w_hit[gi])
            );
        end
    endgenerate

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_count, r_out_found, r_out_status};

endmodule

FILE: rtl/core/alc_cell.sv
// ============================================================================
// alc_cell: one list entry
// Holds one value and one search hit bit, and trades them with its neighbors.
// ============================================================================
module alc_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  alc_pkg::t_cell_cmd        i_cmd,
    input  logic [alc_pkg::VALUE_W-1:0] i_prev_entry,
    input  logic [alc_pkg::VALUE_W-1:0] i_next_entry,
    input  logic                      i_next_hit,
    output logic [alc_pkg::VALUE_W-1:0] o_entry,
    output logic                      o_hit
);
    import alc_pkg::*;

    localparam logic [31:0] IDX_W = 32'(IDX);

    logic [VALUE_W-1:0] r_entry;
    logic [VALUE_W-1:0] n_entry;
    logic               r_hit;
    logic               n_hit;
    logic [31:0]        w_pos;
    logic [31:0]        w_fill;

    assign w_pos  = 32'(i_cmd.position);
    assign w_fill = 32'(i_cmd.fill);

    always_comb begin
        n_entry = r_entry;
        n_hit   = r_hit;
        case (i_cmd.op)
            C_APPEND: begin
                if (IDX_W == w_fill) begin
                    n_entry = i_cmd.value;
                end
            end
            C_INSERT: begin
                if (IDX_W == w_pos) begin
                    n_entry = i_cmd.value;
                end else if (IDX_W > w_pos) begin
                    n_entry = i_prev_entry;
                end
            end
            C_DELETE: begin
                if (IDX_W >= w_pos) begin
                    n_entry = i_next_entry;
                end
            end
            C_MATCH: begin
                // Only entries below the fill take part in a search.
                n_hit = (r_entry == i_cmd.value) && (IDX_W < w_fill);
            end
            C_SHIFT: begin
                n_hit = i_next_hit;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

FILE: rtl/core/alc_checker.sv
// ============================================================================
// alc_checker: port-level checks for the array list engine
// Watches the result channel and is bound to the top level.
// ============================================================================
module alc_checker #(
    parameter int unsigned DEPTH = 64
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [alc_pkg::OUT_W-1:0]     o_m_tdata
);
    import alc_pkg::*;

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Only a successful search reports a nonzero position.
    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] != ST_OK) |-> o_m_tdata[7:2] == '0)
        else $error("position reported on a failed operation");

    // The list never grows past its storage.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> 32'(o_m_tdata[14:8]) <= 32'(DEPTH))
        else $error("count exceeds depth");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind array_list_engine_core alc_checker #(.DEPTH(DEPTH)) u_alc_checker (.*);

FILE: test/tb_array_list_engine_core.sv
// ============================================================================
// tb_array_list_engine_core: self-checking bench for the array list engine
// Drives append, insert, delete and search items with random idling on both
// streams, tracks the list contents and the capacity in a scoreboard, and
// checks every result field against the tracked list.
// ============================================================================
module tb_array_list_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    import alc_pkg::*;

    localparam int LIST_DEPTH = 64;
    localparam int PHASES     = 11;

    typedef struct {
        t_status             status;
        logic [POS_W-1:0]    found;
        logic [COUNT_W-1:0]  count;
    } t_list_reply;

    // Tracks the list as the block should hold it and the replies still owed.
    class list_tracker;
        logic [VALUE_W-1:0]  stored[$];
        logic [COUNT_W-1:0]  capacity;
        t_list_reply         awaited[$];
        int                  errors;

        function new();
            capacity = 7'd64;
            errors   = 0;
        endfunction

        function void set_capacity(logic [COUNT_W-1:0] c);
            capacity = c;
        endfunction

        function int fill();
            return stored.size();
        endfunction

        function logic [VALUE_W-1:0] entry(int i);
            return stored[i];
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_op(t_op op, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] val);
            t_list_reply r;
            int          lim;
            lim      = (capacity > LIST_DEPTH) ? LIST_DEPTH : int'(capacity);
            r.status = ST_OK;
            r.found  = '0;
            case (op)
                OP_APPEND: begin
                    if (stored.size() >= lim) r.status = ST_FULL;
                    else stored.push_back(val);
                end
                OP_INSERT: begin
                    // The full check wins over a bad position.
                    if (stored.size() >= lim) r.status = ST_FULL;
                    else if (int'(pos) > stored.size()) r.status = ST_BADIDX;
                    else stored.insert(int'(pos), val);
                end
                OP_DELETE: begin
                    if (int'(pos) >= stored.size()) r.status = ST_BADIDX;
                    else stored.delete(int'(pos));
                end
                default: begin
                    r.status = ST_NOKEY;
                    for (int i = 0; i < stored.size() && r.status == ST_NOKEY; i++) begin
                        if (stored[i] == val) begin
                            r.status = ST_OK;
                            r.found  = i[POS_W-1:0];
                        end
                    end
                end
            endcase
            r.count = COUNT_W'(stored.size());
            awaited.push_back(r);
        endfunction

        function void check_reply(logic [OUT_W-1:0] d);
            t_list_reply r;
            if (awaited.size() == 0) begin
                $display("%0t: result %h arrived with none expected", $time, d);
                errors++;
                return;
            end
            r = awaited.pop_front();
            if (d[1:0] != r.status) begin
                $display("%0t: status expected %0d, got %0d", $time, r.status, d[1:0]);
                errors++;
            end
            if (d[7:2] != r.found) begin
                $display("%0t: found_position expected %0d, got %0d", $time, r.found, d[7:2]);
                errors++;
            end
            if (d[14:8] != r.count) begin
                $display("%0t: count expected %0d, got %0d", $time, r.count, d[14:8]);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [COUNT_W-1:0]  i_cfg_data  = '0;
    logic                i_s_tvalid  = 1'b0;
    logic                o_s_tready;
    logic [IN_W-1:0]     i_s_tdata   = '0;  // position[5:0], value[37:6]
    logic [1:0]          i_s_tuser   = '0;  // op[1:0]
    logic                o_m_tvalid;
    logic                i_m_tready  = 1'b0;
    logic [OUT_W-1:0]    o_m_tdata;         // status[1:0], found[7:2], count[14:8]

    list_tracker         tracker = new();
    logic [VALUE_W-1:0]  value_pool[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                            32'h8000_0000, 32'h0000_0001, 32'h5A5A_5A5A,
                                            32'hA5A5_A5A5, 32'h0000_0100};
    int                  rx_stall_pct = 0;
    int                  rx_hold_req  = 0;

    array_list_engine_core #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb_array_list_engine_core: FAIL");
        $finish;
    end

    // Result side: checks each accepted item, then picks the next ready level.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
                tracker.check_reply(o_m_tdata);
            end
            if (rx_hold_req != 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < rx_stall_pct) begin
                stall_left = $urandom_range(1, 13) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_op(t_op op, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] val);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, val, pos};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        tracker.note_op(op, pos, val);
    endtask

    task automatic rest_input(int cycles);
        i_s_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [COUNT_W-1:0] c);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= c;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.set_capacity(c);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(bit prefer_stored);
        int n;
        int r;
        n = tracker.fill();
        r = $urandom_range(0, 9);
        if (n > 0 && (prefer_stored ? r < 6 : r < 3)) return tracker.entry($urandom_range(0, n - 1));
        if (r < 7) return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Mostly well-formed operations on the current list, with some noise.
    task automatic random_item(int add_pct, bit gappy);
        t_op               op;
        logic [POS_W-1:0]  pos;
        int                n;
        int                r;
        if (gappy && $urandom_range(0, 99) < 12) rest_input($urandom_range(1, 13));
        n = tracker.fill();
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 4) begin
            send_op(t_op'($urandom_range(0, 3)), POS_W'($urandom_range(0, 63)), $urandom);
            return;
        end
        if (r < add_pct) op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
        else if (r < add_pct + (100 - add_pct) * 2 / 5) op = OP_DELETE;
        else op = OP_SEARCH;
        if ($urandom_range(0, 99) < 15) pos = POS_W'($urandom_range(0, 63));
        else if (op == OP_DELETE) pos = (n > 0) ? POS_W'($urandom_range(0, n - 1)) : '0;
        else pos = POS_W'($urandom_range(0, (n > 63) ? 63 : n));
        send_op(op, pos, pick_value(op == OP_SEARCH));
    endtask

    initial begin : stimulus
        int cap_plan[PHASES];
        int add_plan[PHASES];
        int len_plan[PHASES];
        int stall_plan[PHASES];
        cap_plan   = '{64, 1, 127, 64, 10, 0, 0, 0, 3, 64, 64};
        add_plan   = '{80, 45, 70, 85, 30, 40, 60, 50, 50, 75, 55};
        len_plan   = '{110, 70, 120, 130, 110, 70, 110, 110, 90, 130, 180};
        stall_plan = '{15, 20, 0, 12, 15, 25, 10, 0, 15, 12, 0};
        cap_plan[6] = $urandom_range(2, 63);
        cap_plan[7] = $urandom_range(65, 126);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rx_stall_pct = 10;

        // Directed part at the reset capacity.
        send_op(OP_SEARCH, 6'd0, 32'h0000_0000);   // empty list, no key
        send_op(OP_DELETE, 6'd0, 32'h0);           // nothing to delete
        send_op(OP_INSERT, 6'd1, 32'h1);           // past the end
        send_op(OP_INSERT, 6'd0, 32'h5);
        send_op(OP_APPEND, 6'd0, 32'h7FFF_FFFF);
        send_op(OP_APPEND, 6'd63, 32'h8000_0000);
        send_op(OP_APPEND, 6'd0, 32'h0000_0000);
        send_op(OP_APPEND, 6'd0, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 6'd5, 32'h1234_5678);   // at the end, acts as an append
        send_op(OP_INSERT, 6'd2, 32'h5);
        send_op(OP_SEARCH, 6'd0, 32'h5);           // first of two copies
        send_op(OP_SEARCH, 6'd0, 32'h8000_0000);
        send_op(OP_SEARCH, 6'd0, 32'hDEAD_BEEF);
        send_op(OP_INSERT, 6'd63, 32'h1);
        send_op(OP_DELETE, 6'd63, 32'h0);
        send_op(OP_DELETE, 6'd0, 32'h0);
        send_op(OP_SEARCH, 6'd0, 32'h5);
        send_op(OP_DELETE, 6'd5, 32'h0);
        send_op(OP_DELETE, 6'd5, 32'h0);           // at the count
        send_op(OP_SEARCH, 6'd0, 32'hFFFF_FFFF);

        // A zero capacity refuses every add, whatever the position.
        write_capacity(7'd0);
        send_op(OP_APPEND, 6'd0, 32'h3);
        send_op(OP_INSERT, 6'd0, 32'h3);
        send_op(OP_INSERT, 6'd63, 32'h3);
        send_op(OP_DELETE, 6'd1, 32'h0);
        send_op(OP_SEARCH, 6'd0, 32'h1234_5678);

        for (int p = 0; p < PHASES; p++) begin
            write_capacity(COUNT_W'(cap_plan[p]));
            rx_stall_pct = stall_plan[p];
            // Stall the result side long enough that the input backs up.
            if (p == 0) rx_hold_req = 70;
            for (int k = 0; k < len_plan[p]; k++) begin
                if (p == 3 && k == 60) wait_drained();
                random_item(add_plan[p], stall_plan[p] != 0);
            end
        end

        wait_drained();
        repeat (80) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tb_array_list_engine_core: PASS");
        end else begin
            $display("tb_array_list_engine_core: FAIL");
        end
        $finish;
    end

endmodule
